// ===== rtl/coe_pkg.sv =====
`default_nettype none

package coe_pkg;

  localparam int MAX_LEN                   = 16;
  localparam int CHARSET_DEPTH             = 64;
  localparam int SYM_CAP_SHIFT             = 6;
  localparam int SYMBOLS_PER_CANDIDATE_CAP = 1 << SYM_CAP_SHIFT;

  localparam int DIGIT_W     = $clog2(CHARSET_DEPTH);
  localparam int POS_W       = 4;
  localparam int LEN_W       = 5;
  localparam int BASE_W      = 7;
  localparam int SYMBOL_W    = 21;
  localparam int OPCODE_W    = 2;
  localparam int COUNT_W     = 20;
  localparam int SYM_COUNT_W = 27;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [LEN_W-1:0]   MIN_LEN_RST   = LEN_W'(1);
  localparam logic [LEN_W-1:0]   MAX_LEN_RST   = LEN_W'(4);
  localparam logic [BASE_W-1:0]  CSET_SIZE_RST = '0;
  localparam logic [COUNT_W-1:0] MAX_COUNT_RST = COUNT_W'(100000);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_NEXT    = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN   = 2'd0,
    CFG_MAX_LEN   = 2'd1,
    CFG_CSET_SIZE = 2'd2,
    CFG_MAX_COUNT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DIGIT_W-1:0]  entry_index;
    logic [SYMBOL_W-1:0] entry_symbol;
  } in_item_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] code_point;
    logic [POS_W-1:0]    position;
    logic [LEN_W-1:0]    length;
    logic                last_of_run;
    logic                exhausted;
  } out_item_t;

  typedef struct packed {
    logic load_entry;
    logic restart;
    logic emit;
    logic exhaust;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic last_pos;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/coe_ctrl.sv =====
`default_nettype none

module coe_ctrl import coe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  in_item_t     in_data,
  output logic         in_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_EXH  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            OP_LOAD:    cmd.load_entry = 1'b1;
            OP_RESTART: cmd.restart    = 1'b1;
            OP_NEXT:    state_nxt      = status.at_limit ? S_EXH : S_EMIT;
            default:    ;
          endcase
        end
      end
      S_EMIT: begin
        // one code point per cycle while the output register can take it
        cmd.emit = status.out_free;
        if (status.out_free && status.last_pos) begin
          state_nxt = S_IDLE;
        end
      end
      S_EXH: begin
        cmd.exhaust = status.out_free;
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/coe_datapath.sv =====
`default_nettype none

module coe_datapath import coe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_data
);

  logic [LEN_W-1:0]       min_len_r;
  logic [LEN_W-1:0]       max_len_r;
  logic [BASE_W-1:0]      cset_size_r;
  logic [COUNT_W-1:0]     max_count_r;

  logic [SYMBOL_W-1:0]    cset_mem [CHARSET_DEPTH];
  logic [SYMBOL_W-1:0]    rd_data_r;

  logic [DIGIT_W-1:0]     digit_r  [MAX_LEN];
  logic [DIGIT_W-1:0]     digit_nxt[MAX_LEN];
  logic [BASE_W-1:0]      digit_inc[MAX_LEN];
  logic [MAX_LEN-1:0]     wrap;
  logic                   carry;

  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       len_inc;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       rd_pos;
  logic [COUNT_W-1:0]     cand_count_r;
  logic [SYM_COUNT_W-1:0] sym_count_r;
  logic                   finished_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [BASE_W-1:0]      base;
  logic [SYM_COUNT_W-1:0] sym_cap;
  logic                   last_pos;

  assign base    = (cset_size_r > BASE_W'(CHARSET_DEPTH)) ? BASE_W'(CHARSET_DEPTH)
                                                         : cset_size_r;
  assign sym_cap = SYM_COUNT_W'({max_count_r, {SYM_CAP_SHIFT{1'b0}}});
  assign len_inc = len_r + LEN_W'(1);
  assign last_pos = ((LEN_W'(pos_r) + LEN_W'(1)) == len_r);

  assign status.at_limit = finished_r
                        || (base == '0)
                        || (len_r == '0)
                        || (len_r > max_len_r)
                        || (len_r > LEN_W'(MAX_LEN))
                        || (cand_count_r >= max_count_r)
                        || (sym_count_r >= sym_cap);
  assign status.last_pos = last_pos;
  assign status.out_free = !out_valid_r || !out_stall;

  // odometer step: rightmost active digit counts, a wrap carries left
  always_comb begin
    for (int p = 0; p < MAX_LEN; p++) begin
      digit_inc[p] = BASE_W'(digit_r[p]) + BASE_W'(1);
      wrap[p]      = (digit_inc[p] >= base);
    end
  end

  always_comb begin
    carry = 1'b1;
    for (int p = MAX_LEN - 1; p >= 0; p--) begin
      digit_nxt[p] = digit_r[p];
      if (LEN_W'(p) < len_r) begin
        if (carry) begin
          digit_nxt[p] = wrap[p] ? '0 : digit_inc[p][DIGIT_W-1:0];
        end
        carry = carry & wrap[p];
      end
    end
  end

  // read one ahead so the symbol for the next position is ready
  assign rd_pos = cmd.emit ? (pos_r + POS_W'(1)) : pos_r;

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      cset_mem[in_data.entry_index] <= in_data.entry_symbol;
    end
    rd_data_r <= cset_mem[digit_r[rd_pos]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r    <= MIN_LEN_RST;
      max_len_r    <= MAX_LEN_RST;
      cset_size_r  <= CSET_SIZE_RST;
      max_count_r  <= MAX_COUNT_RST;
      for (int p = 0; p < MAX_LEN; p++) begin
        digit_r[p] <= '0;
      end
      len_r        <= '0;
      pos_r        <= '0;
      cand_count_r <= '0;
      sym_count_r  <= '0;
      finished_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_LEN:   min_len_r   <= cfg_data[LEN_W-1:0];
          CFG_MAX_LEN:   max_len_r   <= cfg_data[LEN_W-1:0];
          CFG_CSET_SIZE: cset_size_r <= cfg_data[BASE_W-1:0];
          CFG_MAX_COUNT: max_count_r <= cfg_data[COUNT_W-1:0];
          default:       ;
        endcase
      end

      if (cmd.restart) begin
        for (int p = 0; p < MAX_LEN; p++) begin
          digit_r[p] <= '0;
        end
        len_r        <= (min_len_r == '0) ? LEN_W'(1) : min_len_r;
        cand_count_r <= '0;
        sym_count_r  <= '0;
        finished_r   <= 1'b0;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_pos) begin
          pos_r <= '0;
          for (int p = 0; p < MAX_LEN; p++) begin
            digit_r[p] <= digit_nxt[p];
          end
          cand_count_r <= cand_count_r + COUNT_W'(1);
          sym_count_r  <= sym_count_r + SYM_COUNT_W'(len_r);
          if (carry) begin
            len_r <= len_inc;
            if (len_inc == '0) begin
              finished_r <= 1'b1;
            end
          end
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end else if (cmd.exhaust) begin
        out_valid_r <= 1'b1;
        finished_r  <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.code_point  <= rd_data_r;
      out_data_r.position    <= pos_r;
      out_data_r.length      <= len_r;
      out_data_r.last_of_run <= last_pos;
      out_data_r.exhausted   <= 1'b0;
    end else if (cmd.exhaust) begin
      out_data_r.code_point  <= '0;
      out_data_r.position    <= '0;
      out_data_r.length      <= '0;
      out_data_r.last_of_run <= 1'b1;
      out_data_r.exhausted   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/charset_odometer_enumerator.sv =====
`default_nettype none

// channel  direction  handshake              payload
// in_      input      in_valid / in_stall    in_item_t   (opcode, entry_index, entry_symbol)
// out_     output     out_valid / out_stall  out_item_t  (code_point .. exhausted)
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A next item is accepted in idle; the emit sequencer then hands out one code point
// per cycle unless stalled, from the charset RAM, whose read is registered one ahead.
// Load and restart items are taken in idle; an exhausted item goes through the exhaust state.
// Synchronous active-low reset; the charset RAM is not cleared and needs no pass.
// out_stall holds the sequencer; in_stall is high while a next item is in flight.
// cfg_ready is always high.

module charset_odometer_enumerator import coe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  coe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  coe_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/coe_checker.sv =====
`default_nettype none

module coe_checker import coe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_exh_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.exhausted |->
      out_data.last_of_run && (out_data.length == '0) && (out_data.code_point == '0))
    else $error("malformed exhausted result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.exhausted |->
      (LEN_W'(out_data.position) < out_data.length)
      && (out_data.last_of_run == ((LEN_W'(out_data.position) + LEN_W'(1))
                                   == out_data.length)))
    else $error("position inconsistent with length");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && ((in_data.opcode == OP_LOAD) || (in_data.opcode == OP_RESTART))
      |=> !in_stall)
    else $error("load or restart transfer did not free the input");

endmodule

bind charset_odometer_enumerator coe_checker u_coe_checker (.*);

`default_nettype wire
